>>> design/dbm_pkg.sv
// dbm_pkg: shared types and codes for the dibit bus master
// used by dbm_front, dbm_back and dibit_bus_master; no dependencies
package dbm_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_TXN    = 2'd1,
    ST_DIRECTION = 2'd2
  } status_t;

  localparam int unsigned COUNT_W = 17;

  // per-job result fields, shared by every result of the job
  typedef struct packed {
    logic               beat_valid;
    logic               beat_write;
    logic               byte_valid;
    logic [7:0]         read_byte;
    logic [COUNT_W-1:0] remaining;
    status_t            status;
  } job_info_t;

endpackage

>>> design/dibit_bus_master.sv
// dibit_bus_master: master side of a 2-bit strobed bus
// depends on dbm_pkg, dbm_front, dbm_queue, dbm_back
//
// input channel: push/full. each transaction carries one command:
//   start (length dibits then address bytes, LENGTH_DIBITS + 4*ADDRESS_BYTES
//   beats, 21 by default), write data byte (4 beats) or read beat (1 beat).
//   misdirected or stray commands give one result with no pulse and a status.
// result channel: empty/pop, one result per bus pulse; last marks the final
//   result of each input transaction.
// taken commands go via the job queue into the back-end result register.
// throughput: one result per cycle while pop is high and a job is loaded; the
//   beat counter in the back end sets how many results a command has (1, 4 or 21).
// a two-entry job queue sits between the front end and the beat sequencer,
//   so new commands are taken while earlier beats are still being popped.
// reset clears the transaction state and the queue; no transaction is open.
// when the receiver stalls, the current result holds; once the queue fills,
//   full rises and stays high until a job is fetched by the back end.
module dibit_bus_master #(
  parameter int unsigned LENGTH_DIBITS = 5,
  parameter int unsigned ADDRESS_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [15:0] transfer_length,
  input  logic        write_flag,
  input  logic [31:0] address,
  input  logic [7:0]  data_byte,
  input  logic        wait_level,
  input  logic [1:0]  read_dibit,
  output logic        empty,
  input  logic        pop,
  output logic        beat_valid,
  output logic        beat_write,
  output logic [1:0]  beat_dibit,
  output logic        byte_valid,
  output logic [7:0]  read_byte,
  output logic [16:0] remaining_bytes,
  output logic [1:0]  status,
  output logic        last
);

  localparam int unsigned NBEATS = LENGTH_DIBITS + 4 * ADDRESS_BYTES;
  localparam int unsigned DW     = 2 * NBEATS;
  localparam int unsigned CW     = $clog2(NBEATS + 1);
  localparam int unsigned QW     = $bits(dbm_pkg::job_info_t) + CW + DW;

  dbm_pkg::job_info_t f_info, q_info;
  logic [CW-1:0]      f_nbeats, q_nbeats;
  logic [DW-1:0]      f_data, q_data;
  logic [QW-1:0]      q_wdata, q_rdata;
  logic               accept;
  logic               q_pop;
  logic               q_empty;

  assign accept  = push && !full;
  assign q_wdata = {f_info, f_nbeats, f_data};
  assign {q_info, q_nbeats, q_data} = q_rdata;

  dbm_front #(
    .LENGTH_DIBITS (LENGTH_DIBITS),
    .ADDRESS_BYTES (ADDRESS_BYTES),
    .NBEATS        (NBEATS),
    .DW            (DW),
    .CW            (CW)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .command         (command),
    .transfer_length (transfer_length),
    .write_flag      (write_flag),
    .address         (address),
    .data_byte       (data_byte),
    .wait_level      (wait_level),
    .read_dibit      (read_dibit),
    .job_info        (f_info),
    .job_nbeats      (f_nbeats),
    .job_data        (f_data)
  );

  dbm_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (q_wdata),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  dbm_back #(
    .DW (DW),
    .CW (CW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_info          (q_info),
    .q_nbeats        (q_nbeats),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .beat_valid      (beat_valid),
    .beat_write      (beat_write),
    .beat_dibit      (beat_dibit),
    .byte_valid      (byte_valid),
    .read_byte       (read_byte),
    .remaining_bytes (remaining_bytes),
    .status          (status),
    .last            (last)
  );

endmodule

>>> design/dbm_front.sv
// dbm_front: takes input items, tracks transaction state and builds bus jobs
// depends on dbm_pkg
module dbm_front #(
  parameter int unsigned LENGTH_DIBITS = 5,
  parameter int unsigned ADDRESS_BYTES = 4,
  parameter int unsigned NBEATS        = LENGTH_DIBITS + 4 * ADDRESS_BYTES,
  parameter int unsigned DW            = 2 * NBEATS,
  parameter int unsigned CW            = $clog2(NBEATS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          command,
  input  logic [15:0]         transfer_length,
  input  logic                write_flag,
  input  logic [31:0]         address,
  input  logic [7:0]          data_byte,
  input  logic                wait_level,
  input  logic [1:0]          read_dibit,
  output dbm_pkg::job_info_t  job_info,
  output logic [CW-1:0]       job_nbeats,
  output logic [DW-1:0]       job_data
);

  localparam int unsigned AW = 8 * ADDRESS_BYTES;
  localparam int unsigned LW = 2 * LENGTH_DIBITS;

  logic [dbm_pkg::COUNT_W-1:0] bytes_left, bytes_left_next;
  logic                        write_mode, write_mode_next;
  logic [7:0]                  read_shift, read_shift_next;
  logic [1:0]                  dibits_taken, dibits_taken_next;
  logic                        held_write, held_write_next;
  logic [1:0]                  held_dibit, held_dibit_next;

  logic [63:0]   addr_ext;
  logic [DW-1:0] start_vec;
  logic [7:0]    shift_in;
  logic [1:0]    taken_in;

  function automatic logic [dbm_pkg::COUNT_W-1:0] byte_count(input logic [15:0] len);
    logic [dbm_pkg::COUNT_W-1:0] r;
    if (len inside {16'd1, 16'd2, 16'd4}) begin
      r = {1'b0, len};
    end else if (len inside {16'd6, 16'd7}) begin
      r = dbm_pkg::COUNT_W'(8);
    end else begin
      r = {1'b0, len} + dbm_pkg::COUNT_W'(8);
    end
    return r;
  endfunction

  // address bytes above the fourth go out as zero
  assign addr_ext  = {32'd0, address};
  assign start_vec = {addr_ext[AW-1:0], transfer_length[LW-1:0]};
  assign shift_in  = {read_dibit, read_shift[7:2]};
  assign taken_in  = dibits_taken + 2'd1;

  always_comb begin
    bytes_left_next   = bytes_left;
    write_mode_next   = write_mode;
    read_shift_next   = read_shift;
    dibits_taken_next = dibits_taken;
    held_write_next   = held_write;
    held_dibit_next   = held_dibit;

    job_info.beat_valid = 1'b0;
    job_info.beat_write = 1'b0;
    job_info.byte_valid = 1'b0;
    job_info.read_byte  = 8'd0;
    job_info.status     = dbm_pkg::ST_OK;
    job_nbeats          = CW'(1);
    job_data            = '0;

    case (command)
      dbm_pkg::CMD_START: begin
        write_mode_next     = write_flag;
        bytes_left_next     = byte_count(transfer_length);
        read_shift_next     = 8'd0;
        dibits_taken_next   = 2'd0;
        held_write_next     = write_flag;
        held_dibit_next     = start_vec[DW-1 -: 2];
        job_info.beat_valid = 1'b1;
        job_info.beat_write = write_flag;
        job_nbeats          = CW'(NBEATS);
        job_data            = start_vec;
      end
      dbm_pkg::CMD_WRITE, dbm_pkg::CMD_READ: begin
        if (bytes_left == '0) begin
          job_info.status = dbm_pkg::ST_NO_TXN;
        end else if ((command == dbm_pkg::CMD_WRITE) != write_mode) begin
          job_info.status = dbm_pkg::ST_DIRECTION;
        end else if (command == dbm_pkg::CMD_WRITE) begin
          held_write_next     = 1'b1;
          held_dibit_next     = data_byte[7:6];
          bytes_left_next     = bytes_left - dbm_pkg::COUNT_W'(1);
          job_info.beat_valid = 1'b1;
          job_info.beat_write = 1'b1;
          job_nbeats          = CW'(4);
          job_data            = DW'(data_byte);
        end else begin
          job_info.beat_valid = 1'b1;
          job_info.beat_write = held_write;
          job_data            = DW'(held_dibit);
          if (!wait_level) begin
            dibits_taken_next = taken_in;
            read_shift_next   = shift_in;
            if (taken_in == 2'd0) begin
              job_info.byte_valid = 1'b1;
              job_info.read_byte  = shift_in;
              read_shift_next     = 8'd0;
              bytes_left_next     = bytes_left - dbm_pkg::COUNT_W'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase

    job_info.remaining = bytes_left_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left   <= '0;
      write_mode   <= 1'b0;
      read_shift   <= 8'd0;
      dibits_taken <= 2'd0;
      held_write   <= 1'b0;
      held_dibit   <= 2'd0;
    end else if (accept) begin
      bytes_left   <= bytes_left_next;
      write_mode   <= write_mode_next;
      read_shift   <= read_shift_next;
      dibits_taken <= dibits_taken_next;
      held_write   <= held_write_next;
      held_dibit   <= held_dibit_next;
    end
  end

  // partial byte is empty whenever no dibit is pending
  assert property (@(posedge clk) disable iff (rst)
    dibits_taken == 2'd0 |-> read_shift == 8'd0)
    else $error("read shift not clear at byte boundary");

endmodule

>>> design/dbm_queue.sv
// dbm_queue: two-entry job queue between front and back
// no dependencies
module dbm_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full) && !(rd_en && empty) && count != 2'd3)
    else $error("job queue overrun or underrun");

endmodule

>>> design/dbm_back.sv
// dbm_back: plays queued jobs out as bus beats, one result per cycle
// while pop is high; depends on dbm_pkg
module dbm_back #(
  parameter int unsigned DW = 42,
  parameter int unsigned CW = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  dbm_pkg::job_info_t  q_info,
  input  logic [CW-1:0]       q_nbeats,
  input  logic [DW-1:0]       q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output logic                beat_valid,
  output logic                beat_write,
  output logic [1:0]          beat_dibit,
  output logic                byte_valid,
  output logic [7:0]          read_byte,
  output logic [16:0]         remaining_bytes,
  output logic [1:0]          status,
  output logic                last
);

  logic               busy;
  dbm_pkg::job_info_t info;
  logic [CW-1:0]      cnt;
  logic [DW-1:0]      data;
  logic               taken;

  assign taken = pop && busy;
  assign q_pop = !q_empty && (!busy || (taken && last));

  assign empty           = !busy;
  assign last            = cnt == CW'(1);
  assign beat_valid      = info.beat_valid;
  assign beat_write      = info.beat_write;
  assign beat_dibit      = data[1:0];
  assign byte_valid      = info.byte_valid;
  assign read_byte       = info.read_byte;
  assign remaining_bytes = info.remaining;
  assign status          = info.status;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      info <= q_info;
      data <= q_data;
    end else if (taken) begin
      data <= data >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      cnt  <= q_nbeats;
    end else if (taken) begin
      busy <= !last;
      cnt  <= cnt - CW'(1);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0)
    else $error("busy with no beats left");

  assert property (@(posedge clk) disable iff (rst)
    taken && !last |=> busy)
    else $error("job dropped before its last beat");

  assert property (@(posedge clk) disable iff (rst)
    busy && !pop |=> busy && $stable(cnt) && $stable(data))
    else $error("stalled result changed");

endmodule

>>> tb/sv/bus_beat_monitor.sv
// bus_beat_monitor: watches both channels of dibit_bus_master, predicts the
// beats of every accepted command and compares them with the popped results
// depends on dbm_pkg
`timescale 1ns / 100ps
module bus_beat_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  command,
  input  logic [15:0] transfer_length,
  input  logic        write_flag,
  input  logic [31:0] address,
  input  logic [7:0]  data_byte,
  input  logic        wait_level,
  input  logic [1:0]  read_dibit,
  input  logic        empty,
  input  logic        pop,
  input  logic        beat_valid,
  input  logic        beat_write,
  input  logic [1:0]  beat_dibit,
  input  logic        byte_valid,
  input  logic [7:0]  read_byte,
  input  logic [16:0] remaining_bytes,
  input  logic [1:0]  status,
  input  logic        last,
  output int          fail_count,
  output int          pending
);

  localparam int unsigned LENGTH_DIBITS   = 5;
  localparam int unsigned ADDRESS_BYTES   = 4;
  localparam int unsigned DIBITS_PER_BYTE = 4;

  typedef struct packed {
    logic                        beat_valid;
    logic                        beat_write;
    logic [1:0]                  beat_dibit;
    logic                        byte_valid;
    logic [7:0]                  read_byte;
    logic [dbm_pkg::COUNT_W-1:0] remaining;
    dbm_pkg::status_t            status;
    logic                        last;
  } bus_beat_t;

  bus_beat_t                   due_beats[$];
  logic [dbm_pkg::COUNT_W-1:0] bytes_left;
  logic                        write_mode;
  logic [7:0]                  read_shift;
  logic [1:0]                  dibits_taken;
  logic                        held_write;
  logic [1:0]                  held_dibit;
  int                          errors = 0;

  function automatic logic [dbm_pkg::COUNT_W-1:0] byte_count(input logic [15:0] len);
    case (len)
      16'd1, 16'd2, 16'd4: return dbm_pkg::COUNT_W'(len);
      16'd6, 16'd7: return dbm_pkg::COUNT_W'(8);
      default: return dbm_pkg::COUNT_W'(len) + dbm_pkg::COUNT_W'(8);
    endcase
  endfunction

  // a driven pulse leaves its levels on the pins
  function automatic bus_beat_t pin_beat(input logic wl, input logic [1:0] d);
    bus_beat_t b;
    b = '0;
    held_write = wl;
    held_dibit = d;
    b.beat_valid = 1'b1;
    b.beat_write = wl;
    b.beat_dibit = d;
    return b;
  endfunction

  task automatic predict_beats(input dbm_pkg::cmd_t cmd, input logic [15:0] len,
                               input logic wflag, input logic [31:0] addr,
                               input logic [7:0] data, input logic wait_lvl,
                               input logic [1:0] rd);
    bus_beat_t  run[$];
    bus_beat_t  b;
    logic [7:0] abyte;
    b = '0;
    if (cmd == dbm_pkg::CMD_START) begin
      write_mode   = wflag;
      bytes_left   = byte_count(len);
      read_shift   = '0;
      dibits_taken = '0;
      for (int j = 0; j < LENGTH_DIBITS; j++) run.push_back(pin_beat(wflag, len[2*j +: 2]));
      for (int i = 0; i < ADDRESS_BYTES; i++) begin
        abyte = 8'(64'(addr) >> (8 * i));
        for (int j = 0; j < DIBITS_PER_BYTE; j++)
          run.push_back(pin_beat(wflag, abyte[2*j +: 2]));
      end
    end else if (cmd == dbm_pkg::CMD_NONE) begin
      run.push_back(b);
    end else if (bytes_left == '0) begin
      b.status = dbm_pkg::ST_NO_TXN;
      run.push_back(b);
    end else if ((cmd == dbm_pkg::CMD_WRITE) != write_mode) begin
      b.status = dbm_pkg::ST_DIRECTION;
      run.push_back(b);
    end else if (cmd == dbm_pkg::CMD_WRITE) begin
      for (int j = 0; j < DIBITS_PER_BYTE; j++) run.push_back(pin_beat(1'b1, data[2*j +: 2]));
      bytes_left = bytes_left - dbm_pkg::COUNT_W'(1);
    end else begin
      // read pulse shows whatever is still held on the pins
      b.beat_valid = 1'b1;
      b.beat_write = held_write;
      b.beat_dibit = held_dibit;
      if (!wait_lvl) begin
        read_shift   = {rd, read_shift[7:2]};
        dibits_taken = dibits_taken + 2'd1;
        if (dibits_taken == 2'd0) begin
          b.byte_valid = 1'b1;
          b.read_byte  = read_shift;
          read_shift   = '0;
          bytes_left   = bytes_left - dbm_pkg::COUNT_W'(1);
        end
      end
      run.push_back(b);
    end
    foreach (run[k]) begin
      b           = run[k];
      b.remaining = bytes_left;
      b.last      = (k == run.size() - 1);
      due_beats.push_back(b);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    bus_beat_t b;
    if (rst) begin
      due_beats.delete();
      bytes_left   = '0;
      write_mode   = 1'b0;
      read_shift   = '0;
      dibits_taken = '0;
      held_write   = 1'b0;
      held_dibit   = '0;
    end else begin
      if (pop && !empty) begin
        if (due_beats.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          b = due_beats.pop_front();
          check_field("beat_valid", b.beat_valid, beat_valid);
          check_field("beat_write", b.beat_write, beat_write);
          check_field("beat_dibit", b.beat_dibit, beat_dibit);
          check_field("byte_valid", b.byte_valid, byte_valid);
          check_field("read_byte", b.read_byte, read_byte);
          check_field("remaining_bytes", b.remaining, remaining_bytes);
          check_field("status", b.status, status);
          check_field("last", b.last, last);
        end
      end
      if (push && !full)
        predict_beats(dbm_pkg::cmd_t'(command), transfer_length, write_flag, address,
                      data_byte, wait_level, read_dibit);
    end
    pending    <= due_beats.size();
    fail_count <= errors;
  end

endmodule

>>> tb/sv/testbench.sv
// testbench: drives directed and random command sequences into dibit_bus_master
// under varying idle and stall patterns and gives the verdict
// depends on dbm_pkg, dibit_bus_master and bus_beat_monitor
`timescale 1ns / 100ps
module testbench;

  localparam int unsigned TOTAL_ITEMS = 330;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct {
    dbm_pkg::cmd_t cmd;
    logic [15:0]   len;
    logic          wflag;
    logic [31:0]   addr;
    logic [7:0]    data;
    logic          wait_lvl;
    logic [1:0]    rd;
  } bus_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [1:0]  command = '0;
  logic [15:0] transfer_length = '0;
  logic        write_flag = 1'b0;
  logic [31:0] address = '0;
  logic [7:0]  data_byte = '0;
  logic        wait_level = 1'b0;
  logic [1:0]  read_dibit = '0;
  logic        full, empty, beat_valid, beat_write, byte_valid, last;
  logic [1:0]  beat_dibit, status;
  logic [7:0]  read_byte;
  logic [16:0] remaining_bytes;

  int          fail_count;
  int          pending;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  logic        hold_request = 1'b0;
  logic        hold_done = 1'b0;

  dibit_bus_master i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .transfer_length(transfer_length), .write_flag(write_flag), .address(address),
    .data_byte(data_byte), .wait_level(wait_level), .read_dibit(read_dibit),
    .empty(empty), .pop(pop), .beat_valid(beat_valid), .beat_write(beat_write),
    .beat_dibit(beat_dibit), .byte_valid(byte_valid), .read_byte(read_byte),
    .remaining_bytes(remaining_bytes), .status(status), .last(last)
  );

  bus_beat_monitor i_beat_monitor (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .transfer_length(transfer_length), .write_flag(write_flag), .address(address),
    .data_byte(data_byte), .wait_level(wait_level), .read_dibit(read_dibit),
    .empty(empty), .pop(pop), .beat_valid(beat_valid), .beat_write(beat_write),
    .beat_dibit(beat_dibit), .byte_valid(byte_valid), .read_byte(read_byte),
    .remaining_bytes(remaining_bytes), .status(status), .last(last),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("dibit_bus_master verification failed");
      $finish;
    end
  end

  // receiver side, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      pop <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic bus_cmd_t random_cmd(input dbm_pkg::cmd_t cmd);
    bus_cmd_t c;
    c.cmd      = cmd;
    c.len      = 16'($urandom);
    c.wflag    = 1'($urandom);
    c.addr     = $urandom;
    c.data     = 8'($urandom);
    c.wait_lvl = 1'($urandom);
    c.rd       = 2'($urandom);
    return c;
  endfunction

  task automatic send_cmd(input bus_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    command         <= c.cmd;
    transfer_length <= c.len;
    write_flag      <= c.wflag;
    address         <= c.addr;
    data_byte       <= c.data;
    wait_level      <= c.wait_lvl;
    read_dibit      <= c.rd;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_start(input logic [15:0] len, input logic wflag, input logic [31:0] addr);
    bus_cmd_t c;
    c       = random_cmd(dbm_pkg::CMD_START);
    c.len   = len;
    c.wflag = wflag;
    c.addr  = addr;
    send_cmd(c);
  endtask

  task automatic send_read(input logic wait_lvl, input logic [1:0] rd);
    bus_cmd_t c;
    c          = random_cmd(dbm_pkg::CMD_READ);
    c.wait_lvl = wait_lvl;
    c.rd       = rd;
    send_cmd(c);
  endtask

  initial begin
    bus_cmd_t    c;
    logic [15:0] len;
    int unsigned nbytes;
    logic        wflag;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed
    send_cmd(random_cmd(dbm_pkg::CMD_WRITE));
    send_cmd(random_cmd(dbm_pkg::CMD_READ));
    send_cmd(random_cmd(dbm_pkg::CMD_NONE));
    send_start(16'hffff, 1'b0, 32'hffff_ffff);
    send_read(1'b1, 2'd3);
    send_read(1'b0, 2'd3);
    send_read(1'b0, 2'd3);
    send_cmd(random_cmd(dbm_pkg::CMD_WRITE));
    send_start(16'd4, 1'b0, 32'h0000_0000);
    send_read(1'b0, 2'd3);
    send_read(1'b0, 2'd3);
    send_start(16'd1, 1'b0, 32'h1234_5678);
    send_read(1'b0, 2'd0);
    send_read(1'b0, 2'd1);
    send_read(1'b1, 2'd2);
    send_read(1'b0, 2'd2);
    send_read(1'b0, 2'd3);
    send_read(1'b0, 2'd1);
    send_start(16'd0, 1'b1, 32'h5a5a_a5a5);
    c = random_cmd(dbm_pkg::CMD_WRITE);
    c.data = 8'hff;
    send_cmd(c);
    c.data = 8'h00;
    send_cmd(c);
    send_cmd(random_cmd(dbm_pkg::CMD_READ));

    // random sequences
    hold_request <= 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      case (items_sent * 4 / TOTAL_ITEMS)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 52; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 52; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(7))
          0: begin len = 16'd1; nbytes = 1; end
          1: begin len = 16'd2; nbytes = 2; end
          2: begin len = 16'd4; nbytes = 4; end
          3: begin len = 16'($urandom_range(6, 7)); nbytes = 8; end
          4: begin len = 16'd0; nbytes = 8; end
          5: begin len = 16'd3; nbytes = 11; end
          6: begin len = 16'd5; nbytes = $urandom_range(1, 6); end
          default: begin len = 16'($urandom); nbytes = $urandom_range(0, 5); end
        endcase
        wflag = 1'($urandom);
        send_start(len, wflag, $urandom);
        for (int k = 0; k < nbytes; k++) begin
          if ($urandom_range(99) < 5)
            send_cmd(random_cmd(dbm_pkg::cmd_t'($urandom_range(1, 3))));
          if (wflag) begin
            send_cmd(random_cmd(dbm_pkg::CMD_WRITE));
          end else begin
            for (int j = 0; j < 4; j++) begin
              if ($urandom_range(99) < 20) send_read(1'b1, 2'($urandom));
              send_read(1'b0, 2'($urandom));
            end
          end
        end
        if ($urandom_range(1)) send_cmd(random_cmd(dbm_pkg::cmd_t'($urandom_range(1, 2))));
      end else begin
        send_cmd(random_cmd(dbm_pkg::cmd_t'($urandom_range(0, 3))));
      end
    end
    push <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("dibit_bus_master verification clean");
    end else begin
      $display("dibit_bus_master verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/dbm_pkg.sv
design/dbm_front.sv
design/dbm_queue.sv
design/dbm_back.sv
design/dibit_bus_master.sv
tb/sv/bus_beat_monitor.sv
tb/sv/testbench.sv
